@@ rtl/cau_pkg.sv @@
// ---------------------------------------------------------------------------
// complex arithmetic unit package
// operation codes, status codes and shared types
// ---------------------------------------------------------------------------
`default_nettype none
package cau_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int KIND_W = 3;
	localparam int STAT_W = 2;

	localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
	localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
	localparam logic [KIND_W-1:0] KIND_MOD = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_DBZ = 2'd1;
	localparam logic [STAT_W-1:0] STAT_OVF = 2'd2;

	// sign-magnitude value, magnitude up to 64 bits
	typedef struct packed {
		logic        neg;
		logic [63:0] mag;
	} sm_t;

	// saturate a sign-magnitude value to 32-bit two's complement
	function automatic logic [32:0] sat32(input logic neg, input logic [64:0] m);
		logic [32:0] r;
		if (!neg) begin
			if (m > 65'h7FFFFFFF) r = {1'b1, 32'h7FFFFFFF};
			else                  r = {1'b0, m[31:0]};
		end else begin
			if (m > 65'h80000000) r = {1'b1, 32'h80000000};
			else                  r = {1'b0, 32'(-m[31:0])};
		end
		return r;
	endfunction
endpackage
`default_nettype wire

@@ rtl/complex_arith_unit.sv @@
// ---------------------------------------------------------------------------
// complex arithmetic unit
// pipelined add, subtract, multiply, divide and modulus on Q fixed point
// ---------------------------------------------------------------------------
// usage
//   pulse start with kind and the operands a and b; busy is always low, so a
//   transaction is taken in every cycle that start is high.
//   each transaction gives one result on result_real, result_imag and status,
//   shown for one cycle with done high. the receiver cannot hold results off.
// order
//   every kind passes through stages 1 to 4, the divider chain and the output
//   register on its way from start to done, which keeps results in order.
// throughput
//   one transaction per cycle. the 32 low dividend bits plus FRAC_BITS
//   fraction steps of the divider, and the 32 square root steps running
//   alongside, are each their own pipeline stage, which sets the latency.
// reset
//   arst_n clears the valid bits only; data registers hold whatever they had.
// ---------------------------------------------------------------------------
`default_nettype none
module complex_arith_unit import cau_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [KIND_W-1:0]  kind,
	input  wire logic signed [31:0] a_real,
	input  wire logic signed [31:0] a_imag,
	input  wire logic signed [31:0] b_real,
	input  wire logic signed [31:0] b_imag,
	output logic                    done,
	output logic signed [31:0]      result_real,
	output logic signed [31:0]      result_imag,
	output logic [STAT_W-1:0]       status
);
	localparam int NDIV = 32 + FRAC_BITS;
	localparam int NSQ  = 32;
	localparam int LAT  = 4 + NDIV + 1;

	assign busy = 1'b0;

	// stage 1: magnitudes and signs
	logic [KIND_W-1:0] kind_s1;
	logic [31:0] mar_s1, mai_s1, mbr_s1, mbi_s1;
	logic nar_s1, nai_s1, nbr_s1, nbi_s1;
	logic signed [31:0] ar_s1, ai_s1, br_s1, bi_s1;
	always_ff @(posedge clk) begin
		kind_s1 <= kind;
		ar_s1 <= a_real; ai_s1 <= a_imag; br_s1 <= b_real; bi_s1 <= b_imag;
		nar_s1 <= a_real[31]; mar_s1 <= a_real[31] ? 32'(-a_real) : a_real;
		nai_s1 <= a_imag[31]; mai_s1 <= a_imag[31] ? 32'(-a_imag) : a_imag;
		nbr_s1 <= b_real[31]; mbr_s1 <= b_real[31] ? 32'(-b_real) : b_real;
		nbi_s1 <= b_imag[31]; mbi_s1 <= b_imag[31] ? 32'(-b_imag) : b_imag;
	end

	// stage 2: products (one 32x32 each); add/sub done here too
	logic [KIND_W-1:0] kind_s2;
	logic [63:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2, p_bb_s2, p_cc_s2, p_aa_s2, p_dd_s2;
	logic n_rr_s2, n_ii_s2, n_ri_s2, n_ir_s2;
	logic signed [32:0] sr_s2, si_s2;
	always_ff @(posedge clk) begin
		kind_s2 <= kind_s1;
		p_rr_s2 <= mar_s1 * mbr_s1; n_rr_s2 <= nar_s1 ^ nbr_s1;
		p_ii_s2 <= mai_s1 * mbi_s1; n_ii_s2 <= nai_s1 ^ nbi_s1;
		p_ri_s2 <= mar_s1 * mbi_s1; n_ri_s2 <= nar_s1 ^ nbi_s1;
		p_ir_s2 <= mai_s1 * mbr_s1; n_ir_s2 <= nai_s1 ^ nbr_s1;
		p_bb_s2 <= mbr_s1 * mbr_s1;
		p_cc_s2 <= mbi_s1 * mbi_s1;
		p_aa_s2 <= mar_s1 * mar_s1;
		p_dd_s2 <= mai_s1 * mai_s1;
		if (kind_s1 == KIND_SUB) begin
			sr_s2 <= 33'(ar_s1) - 33'(br_s1);
			si_s2 <= 33'(ai_s1) - 33'(bi_s1);
		end else begin
			sr_s2 <= 33'(ar_s1) + 33'(br_s1);
			si_s2 <= 33'(ai_s1) + 33'(bi_s1);
		end
	end

	// stage 3: signed sums of products as 66-bit two's complement
	logic [KIND_W-1:0] kind_s3;
	logic signed [65:0] mre_s3, mim_s3, dre_s3, dim_s3;
	logic [63:0] den_s3, sq_s3;
	logic signed [32:0] sr_s3, si_s3;
	function automatic logic signed [65:0] sgn(input logic n, input logic [63:0] m);
		return n ? -$signed({2'b0, m}) : $signed({2'b0, m});
	endfunction
	always_ff @(posedge clk) begin
		kind_s3 <= kind_s2;
		mre_s3 <= sgn(n_rr_s2, p_rr_s2) - sgn(n_ii_s2, p_ii_s2);
		mim_s3 <= sgn(n_ri_s2, p_ri_s2) + sgn(n_ir_s2, p_ir_s2);
		dre_s3 <= sgn(n_rr_s2, p_rr_s2) + sgn(n_ii_s2, p_ii_s2);
		dim_s3 <= sgn(n_ir_s2, p_ir_s2) - sgn(n_ri_s2, p_ri_s2);
		den_s3 <= p_bb_s2 + p_cc_s2;
		sq_s3  <= p_aa_s2 + p_dd_s2;
		sr_s3 <= sr_s2; si_s3 <= si_s2;
	end

	// stage 4: sign-magnitude form and the non-divide results
	logic [KIND_W-1:0] kind_s4;
	logic nre_s4, nim_s4;
	logic [64:0] are_s4, aim_s4;
	logic [63:0] den_s4, sq_s4;
	logic [31:0] fre_s4, fim_s4;
	logic fovf_s4;
	logic [65:0] absre, absim, mulre, mulim;
	logic [32:0] pre, pim;
	always_comb begin
		absre = dre_s3[65] ? 66'(-dre_s3) : 66'(dre_s3);
		absim = dim_s3[65] ? 66'(-dim_s3) : 66'(dim_s3);
		mulre = mre_s3[65] ? 66'(-mre_s3) : 66'(mre_s3);
		mulim = mim_s3[65] ? 66'(-mim_s3) : 66'(mim_s3);
		pre = 33'b0; pim = 33'b0;
		case (kind_s3)
			KIND_ADD, KIND_SUB: begin
				pre = sat32(sr_s3[32], 65'(sr_s3[32] ? 33'(-sr_s3) : 33'(sr_s3)));
				pim = sat32(si_s3[32], 65'(si_s3[32] ? 33'(-si_s3) : 33'(si_s3)));
			end
			KIND_MUL: begin
				pre = sat32(mre_s3[65], 65'(mulre >> FRAC_BITS));
				pim = sat32(mim_s3[65], 65'(mulim >> FRAC_BITS));
			end
			default: begin
				pre = 33'b0; pim = 33'b0;
			end
		endcase
	end
	always_ff @(posedge clk) begin
		kind_s4 <= kind_s3;
		nre_s4 <= dre_s3[65]; nim_s4 <= dim_s3[65];
		are_s4 <= absre[64:0]; aim_s4 <= absim[64:0];
		den_s4 <= den_s3; sq_s4 <= sq_s3;
		fre_s4 <= pre[31:0]; fim_s4 <= pim[31:0];
		fovf_s4 <= pre[32] | pim[32];
	end

	// divider chain: the dividend bits above bit 31 are preloaded as the
	// remainder, then the low 32 bits and FRAC_BITS zeros are shifted in, one
	// per stage. a preload at or above the divisor, or a quotient beyond 32
	// bits, is sticky-marked as too large
	logic [64:0] rre [NDIV+1];
	logic [64:0] rim [NDIV+1];
	logic [32:0] qre [NDIV+1];
	logic [32:0] qim [NDIV+1];
	logic [63:0] dd  [NDIV+1];
	logic [63:0] nsq [NSQ+1];
	logic [31:0] rsq [NSQ+1];
	logic [KIND_W-1:0] kd [NDIV+1];
	logic nr_d [NDIV+1];
	logic ni_d [NDIV+1];
	logic [31:0] fre_d [NDIV+1];
	logic [31:0] fim_d [NDIV+1];
	logic fo_d [NDIV+1];
	logic [64:0] dvre [NDIV+1];
	logic [64:0] dvim [NDIV+1];
	logic big_re, big_im;

	assign big_re = ({32'b0, are_s4[64:32]} >= {1'b0, den_s4});
	assign big_im = ({32'b0, aim_s4[64:32]} >= {1'b0, den_s4});
	assign rre[0] = {32'b0, are_s4[64:32]};
	assign rim[0] = {32'b0, aim_s4[64:32]};
	assign qre[0] = {big_re, 32'b0};
	assign qim[0] = {big_im, 32'b0};
	assign dd[0] = den_s4;
	assign kd[0] = kind_s4;
	assign nr_d[0] = nre_s4;
	assign ni_d[0] = nim_s4;
	assign fre_d[0] = fre_s4;
	assign fim_d[0] = fim_s4;
	assign fo_d[0] = fovf_s4;
	assign dvre[0] = are_s4;
	assign dvim[0] = aim_s4;
	assign nsq[0] = sq_s4;
	assign rsq[0] = 32'b0;

	genvar g;
	generate
		for (g = 0; g < NDIV; g++) begin : g_div
			cau_div_stage u_re (
				.clk(clk), .r_in(rre[g]), .b_in(dvre[g][31]), .q_in(qre[g]),
				.d(dd[g]), .r_out(rre[g+1]), .q_out(qre[g+1])
			);
			cau_div_stage u_im (
				.clk(clk), .r_in(rim[g]), .b_in(dvim[g][31]), .q_in(qim[g]),
				.d(dd[g]), .r_out(rim[g+1]), .q_out(qim[g+1])
			);
			always_ff @(posedge clk) begin
				dd[g+1] <= dd[g]; kd[g+1] <= kd[g];
				nr_d[g+1] <= nr_d[g]; ni_d[g+1] <= ni_d[g];
				fre_d[g+1] <= fre_d[g]; fim_d[g+1] <= fim_d[g];
				fo_d[g+1] <= fo_d[g];
				dvre[g+1] <= dvre[g] << 1;
				dvim[g+1] <= dvim[g] << 1;
			end
		end
		for (g = 0; g < NSQ; g++) begin : g_sq
			cau_sqrt_stage #(.STEP(g)) u_sq (
				.clk(clk), .n_in(nsq[g]), .res_in(rsq[g]),
				.n_out(nsq[g+1]), .res_out(rsq[g+1])
			);
		end
	endgenerate

	// square root delay to line up with the divider
	logic [31:0] sqd [NDIV-NSQ+1];
	assign sqd[0] = rsq[NSQ];
	generate
		for (g = 0; g < NDIV - NSQ; g++) begin : g_sqd
			always_ff @(posedge clk) sqd[g+1] <= sqd[g];
		end
	endgenerate

	// output stage
	logic [32:0] ore, oim;
	logic [STAT_W-1:0] ost;
	always_comb begin
		ore = {1'b0, fre_d[NDIV]};
		oim = {1'b0, fim_d[NDIV]};
		ost = fo_d[NDIV] ? STAT_OVF : STAT_OK;
		case (kd[NDIV])
			KIND_DIV: begin
				if (dd[NDIV] == 64'b0) begin
					ore = 33'b0; oim = 33'b0; ost = STAT_DBZ;
				end else begin
					ore = sat32(nr_d[NDIV] && qre[NDIV] != 33'b0, 65'(qre[NDIV]));
					oim = sat32(ni_d[NDIV] && qim[NDIV] != 33'b0, 65'(qim[NDIV]));
					ost = (ore[32] | oim[32]) ? STAT_OVF : STAT_OK;
				end
			end
			KIND_MOD: begin
				ore = sat32(1'b0, 65'(sqd[NDIV-NSQ]));
				oim = 33'b0;
				ost = ore[32] ? STAT_OVF : STAT_OK;
			end
			default: ;
		endcase
	end

	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else         vld_q <= {vld_q[LAT-2:0], start};
	end
	always_ff @(posedge clk) begin
		result_real <= ore[31:0];
		result_imag <= oim[31:0];
		status      <= ost;
	end
	assign done = vld_q[LAT-1];

	// checks
	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("done without a transaction");
	a_stat_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == STAT_OK || status == STAT_DBZ || status == STAT_OVF))
		else $error("bad status code");
endmodule
`default_nettype wire

@@ rtl/cau_div_stage.sv @@
// ---------------------------------------------------------------------------
// cau divider stage
// one restoring step of the scaled quotient, registered
// ---------------------------------------------------------------------------
`default_nettype none
module cau_div_stage import cau_pkg::*; (
	input  wire logic        clk,
	input  wire logic [64:0] r_in,
	input  wire logic        b_in,
	input  wire logic [32:0] q_in,
	input  wire logic [63:0] d,
	output logic      [64:0] r_out,
	output logic      [32:0] q_out
);
	logic [65:0] r2;
	logic        bit_v;
	logic [65:0] rn;
	always_comb begin
		r2 = {r_in, b_in};
		bit_v = (r2 >= {2'b0, d});
		rn = bit_v ? r2 - {2'b0, d} : r2;
	end
	always_ff @(posedge clk) begin
		r_out <= rn[64:0];
		// q_in[32] is a sticky too-large mark
		q_out <= (q_in[32] || q_in[31]) ? {1'b1, q_in[31:0]} : {1'b0, q_in[30:0], bit_v};
	end
endmodule
`default_nettype wire

@@ rtl/cau_sqrt_stage.sv @@
// ---------------------------------------------------------------------------
// cau square root stage
// one digit of the restoring integer square root, registered
// ---------------------------------------------------------------------------
`default_nettype none
module cau_sqrt_stage import cau_pkg::*; #(
	parameter int STEP = 0
) (
	input  wire logic        clk,
	input  wire logic [63:0] n_in,
	input  wire logic [31:0] res_in,
	output logic      [63:0] n_out,
	output logic      [31:0] res_out
);
	localparam int SH = 2 * (31 - STEP);
	logic [65:0] trial;
	logic        take;
	always_comb begin
		// (res + 2^b)^2 - res^2 with b = 31 - STEP
		trial = ({34'b0, res_in} << (32 - STEP)) | (66'd1 << SH);
		take = ({2'b0, n_in} >= trial);
	end
	always_ff @(posedge clk) begin
		n_out   <= take ? 64'({2'b0, n_in} - trial) : n_in;
		res_out <= take ? (res_in | (32'd1 << (31 - STEP))) : res_in;
	end
endmodule
`default_nettype wire

@@ dv/tb.sv @@
// ---------------------------------------------------------------------------
// complex arithmetic unit testbench
// drives add, subtract, multiply, divide, modulus and unused-kind transactions through the
// command interface and checks every result against an in-bench predictor
// ---------------------------------------------------------------------------
module tb;
	import cau_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = FRAC_BITS_DEF;
	localparam int LAT = 4 + 32 + FB + 1;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [31:0] ar, ai, br, bi;
	} op_t;

	typedef struct {
		logic [31:0] re, im;
		logic [STAT_W-1:0] st;
	} res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [KIND_W-1:0] kind = '0;
	logic signed [31:0] a_real = '0, a_imag = '0, b_real = '0, b_imag = '0;
	logic done;
	logic signed [31:0] result_real, result_imag;
	logic [STAT_W-1:0] status;

	op_t pending_ops[$];
	res_t expected_results[$];
	int errors = 0;
	int idle_pct = 0;
	longint cycles = 0;

	complex_arith_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.a_real(a_real), .a_imag(a_imag), .b_real(b_real), .b_imag(b_imag),
		.done(done), .result_real(result_real), .result_imag(result_imag),
		.status(status)
	);

	always #5 clk = ~clk;

	// signed 32-bit to sign and magnitude
	function automatic logic [63:0] magn(input logic [31:0] x, output logic neg);
		neg = x[31];
		return neg ? 64'(-{32'b0, x} & 64'hFFFFFFFF) : 64'(x);
	endfunction

	function automatic logic [63:0] smul(input logic [31:0] x, input logic [31:0] y,
			output logic neg);
		logic nx, ny;
		logic [63:0] m;
		m = magn(x, nx) * magn(y, ny);
		neg = (nx != ny) && m != 0;
		return m;
	endfunction

	function automatic logic [63:0] smsum(input logic n1, input logic [63:0] m1,
			input logic n2, input logic [63:0] m2, output logic neg);
		if (n1 == n2) begin
			neg = n1;
			return m1 + m2;
		end
		if (m1 >= m2) begin
			neg = n1;
			return m1 - m2;
		end
		neg = n2;
		return m2 - m1;
	endfunction

	function automatic logic [31:0] saturate(input logic neg, input logic [64:0] m,
			inout logic ovf);
		if (!neg) begin
			if (m > 65'h7FFFFFFF) begin
				ovf = 1'b1;
				return 32'h7FFFFFFF;
			end
			return m[31:0];
		end
		if (m > 65'h80000000) begin
			ovf = 1'b1;
			return 32'h80000000;
		end
		return -m[31:0];
	endfunction

	// floor(n * 2^FB / d); 2^32 stands for too large
	function automatic logic [64:0] frac_quot(input logic [63:0] n, input logic [63:0] d);
		logic [127:0] q;
		q = ({64'b0, n} << FB) / {64'b0, d};
		return (q > 128'hFFFFFFFF) ? 65'h100000000 : 65'(q);
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
		logic [63:0] r;
		logic [127:0] t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = {64'b0, r | (64'd1 << b)};
			if (t * t <= {64'b0, n}) r = t[63:0];
		end
		return r;
	endfunction

	function automatic res_t predict_result(input op_t op);
		res_t r;
		logic ovf, n1, n2, nr, dn;
		logic [63:0] m1, m2, mr, den;
		r = '{re: 0, im: 0, st: STAT_OK};
		ovf = 1'b0;
		case (op.kind)
			KIND_ADD, KIND_SUB: begin
				m1 = magn(op.ar, n1);
				m2 = magn(op.br, n2);
				if (op.kind == KIND_SUB) n2 = !n2 && m2 != 0;
				mr = smsum(n1, m1, n2, m2, nr);
				r.re = saturate(nr, {1'b0, mr}, ovf);
				m1 = magn(op.ai, n1);
				m2 = magn(op.bi, n2);
				if (op.kind == KIND_SUB) n2 = !n2 && m2 != 0;
				mr = smsum(n1, m1, n2, m2, nr);
				r.im = saturate(nr, {1'b0, mr}, ovf);
			end
			KIND_MUL: begin
				m1 = smul(op.ar, op.br, n1);
				m2 = smul(op.ai, op.bi, n2);
				mr = smsum(n1, m1, !n2 && m2 != 0, m2, nr);
				r.re = saturate(nr, {1'b0, mr >> FB}, ovf);
				m1 = smul(op.ar, op.bi, n1);
				m2 = smul(op.ai, op.br, n2);
				mr = smsum(n1, m1, n2, m2, nr);
				r.im = saturate(nr, {1'b0, mr >> FB}, ovf);
			end
			KIND_DIV: begin
				den = smul(op.br, op.br, dn) + smul(op.bi, op.bi, dn);
				if (den == 0) r.st = STAT_DBZ;
				else begin
					m1 = smul(op.ar, op.br, n1);
					m2 = smul(op.ai, op.bi, n2);
					mr = smsum(n1, m1, n2, m2, nr);
					r.re = saturate(nr, frac_quot(mr, den), ovf);
					m1 = smul(op.ai, op.br, n1);
					m2 = smul(op.ar, op.bi, n2);
					mr = smsum(n1, m1, !n2 && m2 != 0, m2, nr);
					r.im = saturate(nr, frac_quot(mr, den), ovf);
				end
			end
			KIND_MOD: begin
				den = smul(op.ar, op.ar, dn) + smul(op.ai, op.ai, dn);
				r.re = saturate(1'b0, {1'b0, floor_sqrt(den)}, ovf);
			end
			default: ;
		endcase
		if (ovf) r.st = STAT_OVF;
		return r;
	endfunction

	function automatic logic [31:0] rand_part();
		case ($urandom_range(0, 5))
			0: return 32'h80000000 + $urandom_range(0, 3);
			1: return 32'h7FFFFFFF - $urandom_range(0, 3);
			2: return $urandom_range(0, 8) - 4;
			3: return ($urandom_range(0, 1) ? -32'sd1 : 32'sd1) * $urandom_range(0, 32'h3FFFF);
			default: return $urandom;
		endcase
	endfunction

	task automatic add_op(input logic [KIND_W-1:0] k, input logic [31:0] ar,
			input logic [31:0] ai, input logic [31:0] br, input logic [31:0] bi);
		pending_ops.push_back('{kind: k, ar: ar, ai: ai, br: br, bi: bi});
	endtask

	// driver
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && !(start && busy)) begin
			if (pending_ops.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
				op_t op;
				op = pending_ops.pop_front();
				expected_results.push_back(predict_result(op));
				start <= 1'b1;
				kind <= op.kind;
				a_real <= op.ar;
				a_imag <= op.ai;
				b_real <= op.br;
				b_imag <= op.bi;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected transaction re=%h im=%h st=%0d", $time,
					result_real, result_imag, status);
				errors++;
			end else begin
				res_t e;
				e = expected_results.pop_front();
				if (result_real !== e.re) begin
					$display("%0t: result_real expected %h actual %h", $time, e.re, result_real);
					errors++;
				end
				if (result_imag !== e.im) begin
					$display("%0t: result_imag expected %h actual %h", $time, e.im, result_imag);
					errors++;
				end
				if (status !== e.st) begin
					$display("%0t: status expected %0d actual %0d", $time, e.st, status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [31:0] ext[4];
		ext = '{32'h80000000, 32'h7FFFFFFF, 32'h0, 32'hFFFFFFFF};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes of every kind, zero divisor, overflow, unused kinds
		for (int k = 0; k < 5; k++) begin
			add_op(KIND_W'(k), ext[0], ext[0], ext[1], ext[1]);
			add_op(KIND_W'(k), ext[1], ext[1], ext[0], ext[3]);
			add_op(KIND_W'(k), 32'h00010000, 32'h00020000, 32'h00030000, 32'hFFFF0000);
		end
		add_op(KIND_DIV, 32'h00050000, 32'h1, 32'h0, 32'h0);
		add_op(KIND_DIV, ext[1], ext[0], 32'h1, 32'h0);
		add_op(KIND_MOD, 32'h0, 32'h0, 32'h0, 32'h0);
		add_op(3'd5, ext[1], ext[1], ext[1], ext[1]);
		add_op(3'd6, 32'h1, 32'h1, 32'h1, 32'h1);
		add_op(3'd7, ext[0], ext[0], ext[0], ext[0]);

		// phases: no idling, sender idle, receiver phase (cannot stall), both
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 74 : (ph == 3) ? 6 : 0;
			for (int i = 0; i < 325; i++) begin
				logic [KIND_W-1:0] k;
				k = ($urandom_range(0, 39) == 0) ? KIND_W'($urandom_range(5, 7))
					: KIND_W'($urandom_range(0, 4));
				add_op(k, rand_part(), rand_part(),
					$urandom_range(0, 15) == 0 ? 32'h0 : rand_part(),
					$urandom_range(0, 15) == 0 ? 32'h0 : rand_part());
			end
			wait (pending_ops.size() == 0);
			// idle stretch of random length between phases
			repeat ($urandom_range(0, 60)) @(posedge clk);
		end

		wait (pending_ops.size() == 0 && expected_results.size() == 0);
		repeat (LAT + 10) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

@@ complex_arith_unit.f @@
rtl/cau_pkg.sv
rtl/cau_div_stage.sv
rtl/cau_sqrt_stage.sv
rtl/complex_arith_unit.sv
dv/tb.sv
